// ===== rtl/core/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 4;

    // Decoder position within the current string
    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_FIRST   = 2'd1,
        MODE_SECOND  = 2'd2,
        MODE_DISCARD = 2'd3
    } t_mode;

    // Result word kind
    typedef enum logic [STATUS_W-1:0] {
        ST_DATA  = 2'd0,
        ST_OK    = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    // Result of decoding one byte, handed to the output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        t_status           status;
    } t_result;

    localparam logic [BYTE_W-1:0] C_NUL        = 8'h00;
    localparam logic [BYTE_W-1:0] C_PERCENT    = 8'h25;
    localparam logic [BYTE_W-1:0] C_QUESTION   = 8'h3F;
    localparam logic [BYTE_W-1:0] C_HASH       = 8'h23;
    localparam logic [BYTE_W-1:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] C_CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] C_ASCII_TOP  = 8'h7F;
    localparam logic [BYTE_W-1:0] C_CASE_MASK  = 8'hDF;
    localparam logic [BYTE_W-1:0] C_TEN        = 8'd10;
    localparam logic [BYTE_W-1:0] C_PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] C_PRINT_HI   = 8'd126;

    // Hex digit value, modulo 256; letters fold to upper case first
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] folded;
        folded = b & C_CASE_MASK;
        if (b >= C_CHAR_A && b <= C_ASCII_TOP) begin
            return folded - C_CHAR_A + C_TEN;
        end
        return b - C_CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upd_in_stage.sv =====
`default_nettype none

module upd_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [upd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_take,
    output logic                            o_valid,
    output logic      [upd_pkg::BYTE_W-1:0] o_byte
);
    import upd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              n_valid;
    logic              w_load;

    // Accept when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// ===== rtl/core/upd_decode.sv =====
`default_nettype none

module upd_decode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [upd_pkg::BYTE_W-1:0] i_byte,
    output upd_pkg::t_result                o_res
);
    import upd_pkg::*;

    t_mode              r_mode;
    t_mode              n_mode;
    logic [DIGIT_W-1:0] r_high;
    logic [DIGIT_W-1:0] n_high;
    logic [BYTE_W-1:0]  w_digit;
    logic [BYTE_W-1:0]  w_value;
    logic               w_nul;

    assign w_digit = digit_value(i_byte);
    assign w_value = {r_high, {DIGIT_W{1'b0}}} + w_digit;
    assign w_nul   = (i_byte == C_NUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_high <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_high <= n_high;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_high       = r_high;
        o_res.valid  = 1'b0;
        o_res.data   = '0;
        o_res.status = ST_DATA;
        case (r_mode)
            MODE_PLAIN: begin
                if (w_nul) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_OK;
                end else if (i_byte == C_PERCENT) begin
                    n_mode = MODE_FIRST;
                end else if (i_byte == C_QUESTION || i_byte == C_HASH) begin
                    n_mode       = MODE_DISCARD;
                    o_res.valid  = 1'b1;
                    o_res.status = ST_OK;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_byte;
                end
            end
            MODE_FIRST: begin
                if (w_nul) begin
                    n_mode       = MODE_PLAIN;
                    o_res.valid  = 1'b1;
                    o_res.status = ST_ERROR;
                end else begin
                    n_high = w_digit[DIGIT_W-1:0];
                    n_mode = MODE_SECOND;
                end
            end
            MODE_SECOND: begin
                o_res.valid = 1'b1;
                if (w_nul) begin
                    n_mode       = MODE_PLAIN;
                    o_res.status = ST_ERROR;
                end else if (w_value < C_PRINT_LO || w_value > C_PRINT_HI) begin
                    n_mode       = MODE_DISCARD;
                    o_res.status = ST_ERROR;
                end else begin
                    n_mode     = MODE_PLAIN;
                    o_res.data = w_value;
                end
            end
            MODE_DISCARD: begin
                // drop everything up to the terminator
                if (w_nul) begin
                    n_mode = MODE_PLAIN;
                end
            end
            default: begin
                n_mode = MODE_PLAIN;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/upd_out_stage.sv =====
`default_nettype none

module upd_out_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire upd_pkg::t_result             i_res,
    output logic                              o_free,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [upd_pkg::BYTE_W-1:0]   o_byte,
    output logic      [upd_pkg::STATUS_W-1:0] o_status
);
    import upd_pkg::*;

    logic                r_valid;
    logic                n_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic [STATUS_W-1:0] r_status;

    // Slot is free when empty or drained this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte   <= i_res.data;
            r_status <= i_res.status;
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_status = r_status;

endmodule

`default_nettype wire

// ===== rtl/core/uri_percent_decoder_unit.sv =====
// URI percent decoder.
// Input channel (i_valid / o_ready / i_in_byte) carries one byte of an escaped
// URI string per word; a zero byte terminates the string. Output channel
// (o_valid / i_ready / o_out_byte / o_status) carries zero or one word per
// input byte: status 0 is a data byte, 1 ends the string with success, 2 ends
// it with an illegal escape (o_out_byte is zero for both end codes).
// A '%' and the first hex digit produce no word; the second digit produces
// the decoded byte. After '?', '#' or an illegal escape the decoder drops
// bytes up to the next zero byte, which starts a new string.
// An accepted byte lands in the input register, is decoded combinationally and is
// written to the output register, where its word waits for the receiver.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode step between the registers.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to plain mode at the start of a string.
// When the receiver stalls, the output register holds its word; the input
// register still advances bytes that produce no word, and once a byte that
// does is waiting, o_ready drops until the output register drains.
`default_nettype none

module uri_percent_decoder_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [upd_pkg::BYTE_W-1:0]   i_in_byte,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [upd_pkg::BYTE_W-1:0]   o_out_byte,
    output logic      [upd_pkg::STATUS_W-1:0] o_status
);
    import upd_pkg::*;

    logic              w_held_valid;
    logic [BYTE_W-1:0] w_held_byte;
    logic              w_step;
    logic              w_out_free;
    t_result           w_res;

    // Hold the incoming byte
    upd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_in_byte),
        .i_take  (w_step),
        .o_valid (w_held_valid),
        .o_byte  (w_held_byte)
    );

    // Decode the held byte against the current mode
    upd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (w_held_byte),
        .o_res   (w_res)
    );

    // Advance the held byte when it yields no word or the output slot is free
    assign w_step = w_held_valid && (!w_res.valid || w_out_free);

    // Hold the result word until the receiver takes it
    upd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step && w_res.valid),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_byte   (o_out_byte),
        .o_status (o_status)
    );

endmodule

`default_nettype wire

// ===== test/tb_uri_percent_decoder_unit.sv =====
module tb_uri_percent_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    // Give up after this many cycles in which neither channel moves a word.
    // The longest legal quiet stretch is the output hold-off below.
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_BYTES   = 420;

    // One decoded word as the receiver should see it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_status           status;
    } t_decoded_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_in_byte;
    logic                o_valid;
    logic                i_ready;
    logic [BYTE_W-1:0]   o_out_byte;
    logic [STATUS_W-1:0] o_status;

    // Decoder state as the testbench tracks it
    t_mode              dec_mode;
    logic [DIGIT_W-1:0] dec_high;

    // Words still owed by the block, oldest first
    t_decoded_word decoded_words[$];

    // Idling knobs: percent chance of a gap per cycle on each side
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_request = 0;

    int bytes_sent   = 0;
    int strings_sent = 0;
    int mismatches   = 0;
    int n_data       = 0;
    int n_ok         = 0;
    int n_err        = 0;

    uri_percent_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_status   (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Value of one escape digit byte, modulo 256. Bytes from 'A' up to 0x7F
    // fold to upper case and count from ten; all others count from '0'.
    function automatic logic [BYTE_W-1:0] digit_weight(input logic [BYTE_W-1:0] b);
        if (b >= 8'h41 && b <= 8'h7F) begin
            return (b & 8'hDF) - 8'h41 + 8'd10;
        end
        return b - 8'h30;
    endfunction

    // Advance the tracked decoder by one byte; return 1 when the byte yields
    // a word, with that word in w.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output t_decoded_word w);
        logic [BYTE_W-1:0] value;
        bit                emits;
        w     = '{data: '0, status: ST_DATA};
        emits = 1'b1;
        case (dec_mode)
            MODE_PLAIN: begin
                if (b == C_NUL) begin
                    w.status = ST_OK;
                end else if (b == C_PERCENT) begin
                    dec_mode = MODE_FIRST;
                    emits    = 1'b0;
                end else if (b == C_QUESTION || b == C_HASH) begin
                    // Query or fragment ends the path; drop the rest
                    dec_mode = MODE_DISCARD;
                    w.status = ST_OK;
                end else begin
                    w.data = b;
                end
            end
            MODE_FIRST: begin
                if (b == C_NUL) begin
                    dec_mode = MODE_PLAIN;
                    w.status = ST_ERROR;
                end else begin
                    value    = digit_weight(b);
                    dec_high = value[DIGIT_W-1:0];
                    dec_mode = MODE_SECOND;
                    emits    = 1'b0;
                end
            end
            MODE_SECOND: begin
                if (b == C_NUL) begin
                    dec_mode = MODE_PLAIN;
                    w.status = ST_ERROR;
                end else begin
                    value = {dec_high, 4'h0} + digit_weight(b);
                    if (value < C_PRINT_LO || value > C_PRINT_HI) begin
                        dec_mode = MODE_DISCARD;
                        w.status = ST_ERROR;
                    end else begin
                        dec_mode = MODE_PLAIN;
                        w.data   = value;
                    end
                end
            end
            default: begin
                // Discarding: only a zero byte reopens a string
                if (b == C_NUL) begin
                    dec_mode = MODE_PLAIN;
                end
                emits = 1'b0;
            end
        endcase
        return emits;
    endfunction

    // Hex digit character for a nibble, upper or lower case at random
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // Offer one byte, idle first at the current sender rate, hold it until
    // the block takes it, then record the word it should cause.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_decoded_word w;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_in_byte = b;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (decode_byte(b, w)) begin
            decoded_words.push_back(w);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed word has reached the receiver
    task automatic wait_drained();
        i_valid = 1'b0;
        while (decoded_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One string: mostly plain text and well-formed escapes, with some broken
    // escapes, early query/fragment ends and raw noise, closed by a zero.
    task automatic send_string();
        int                n_parts;
        int                kind;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] b;
        n_parts = $urandom_range(1, 12);
        repeat (n_parts) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                b = BYTE_W'($urandom_range(8'h20, 8'h7E));
                if (b == C_PERCENT || b == C_QUESTION || b == C_HASH) begin
                    b = 8'h5F;
                end
                send_byte(b);
            end else if (kind < 75) begin
                v = BYTE_W'($urandom_range(C_PRINT_LO, C_PRINT_HI));
                send_byte(C_PERCENT);
                send_byte(hex_char(v[7:4]));
                send_byte(hex_char(v[3:0]));
            end else if (kind < 85) begin
                // Any digit bytes at all; a zero now and then cuts the escape
                send_byte(C_PERCENT);
                repeat (2) begin
                    b = ($urandom_range(0, 9) == 0) ? C_NUL
                                                    : BYTE_W'($urandom_range(1, 255));
                    send_byte(b);
                end
            end else if (kind < 90) begin
                send_byte($urandom_range(0, 1) ? C_QUESTION : C_HASH);
                repeat ($urandom_range(0, 4)) send_byte(BYTE_W'($urandom_range(1, 255)));
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        send_byte(C_NUL);
        strings_sent++;
    endtask

    task automatic send_random_strings(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            send_string();
        end
    endtask

    // Extremes of the byte range, both escape bounds, every way a string ends
    task automatic test_directed_cases();
        logic [BYTE_W-1:0] script[$];
        script = '{
            8'h61, 8'h01, 8'h80, 8'hFF, 8'h7F, C_NUL,  // pass-through, clean end
            C_PERCENT, 8'h32, 8'h30,                    // lowest legal escape
            C_PERCENT, 8'h37, 8'h65,                    // highest legal escape
            C_PERCENT, 8'h31, 8'h66, C_NUL,             // out of range, then drop
            C_QUESTION, 8'h78, C_NUL,                   // query ends the path
            C_HASH, C_NUL,                              // fragment ends the path
            C_PERCENT, C_NUL,                           // zero in place of a digit
            C_PERCENT, 8'h34, C_NUL                     // zero after one digit
        };
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        foreach (script[k]) begin
            send_byte(script[k]);
        end
    endtask

    task automatic test_streaming();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_strings(PHASE_BYTES);
    endtask

    task automatic test_sender_gaps();
        tx_idle_pct = 73;
        rx_idle_pct = 0;
        send_random_strings(PHASE_BYTES);
    endtask

    task automatic test_receiver_stalls();
        tx_idle_pct = 0;
        rx_idle_pct = 73;
        send_random_strings(PHASE_BYTES);
    endtask

    task automatic test_both_idle();
        tx_idle_pct = 19;
        rx_idle_pct = 19;
        send_random_strings(PHASE_BYTES);
    endtask

    // Hold the receiver off long enough that the block backs up and drops
    // o_ready, keep offering bytes, then pause the sender until all words
    // have drained before resuming.
    task automatic test_output_hold_off();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = HOLD_OFF_LEN;
        repeat (60) send_byte(BYTE_W'($urandom_range(8'h41, 8'h5A)));
        wait_drained();
        send_random_strings(90);
    endtask

    // Receiver: stall at the current rate, or hold off for a requested stretch
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Check each delivered word against the oldest owed one
    always @(posedge i_clk) begin : check_words
        t_decoded_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected word: data %02h status %0d", o_out_byte, o_status);
                end
            end else begin
                want = decoded_words.pop_front();
                if (o_out_byte !== want.data || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("word mismatch: expected data %02h status %0d, got data %02h status %0d",
                                 want.data, want.status, o_out_byte, o_status);
                    end
                end
                case (want.status)
                    ST_DATA: n_data++;
                    ST_OK:   n_ok++;
                    default: n_err++;
                endcase
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = '0;
        dec_mode  = MODE_PLAIN;
        dec_high  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_hold_off();

        // Let the last words drain, then watch a little longer for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d bytes in %0d strings: streaming, sender gaps, receiver stalls,",
                 bytes_sent, strings_sent);
        $display("mixed idling and a long output hold-off; words %0d data, %0d ok, %0d error.",
                 n_data, n_ok, n_err);
        if (mismatches == 0 && decoded_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
